// ===== design/prefix_expression_evaluator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the prefix expression evaluator
// Shared helpers that wrap clocked implication checks.
// ----------------------------------------------------------------------------
`ifndef PREFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define PREFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define PEE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define PEE_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== design/pee_pkg.sv =====
// ----------------------------------------------------------------------------
// pee_pkg
// Types and constants for the prefix expression evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pee_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;

    localparam int KIND_W      = 3;
    localparam int DIGIT_W     = 4;
    localparam int OUT_VALUE_W = 32;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(STACK_DEPTH);

    // token kinds
    localparam logic [KIND_W-1:0] KIND_DIGIT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SUB   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MUL   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEL   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_SEL = 2'd3
    } op_code_t;

    typedef struct packed {
        logic                   is_op;
        op_code_t               code;
        logic [VALUE_WIDTH-1:0] value;
    } entry_t;

endpackage

`default_nettype wire

// ===== design/prefix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// prefix_expression_evaluator
// Stack-based evaluator of prefix expressions, one token per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one token per transaction. s_tdata[2:0] is the kind
//   (digit, add, subtract, multiply, select), s_tdata[6:3] the digit, and
//   s_tlast marks the final token of an expression.
//   Master channel m_*: one result per expression, sent after the token that
//   carries s_tlast. m_tdata[31:0] is the value, m_tdata[33:32] the status.
//   Flow: an operator, an ignored token or an operand dropped on a full
//   stack is handled as it is taken. An operand passes through S_RD, then
//   S_RED for a binary reduction and S_SEL for a select reduction, looping
//   back to S_RD after each reduction, and ends in S_WB, which pushes it;
//   the stack sits in a memory read through one registered port pair and one
//   reduction is evaluated per pass. A last token then passes S_OUT to load
//   the result register. s_tready is low while a token is being worked on.
//   Reset clears the stack count, overflow flag and output valid; stack
//   contents need no clearing. A stalled receiver holds the result in the
//   output register; the block keeps taking tokens until a further result
//   is ready, then waits for the register to free up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "prefix_expression_evaluator_defines.svh"

module prefix_expression_evaluator (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [2:0] kind, [6:3] digit, [7] zero
    input  wire logic [pee_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] value, [33:32] status, [39:34] zero
    output logic [pee_pkg::OUT_TDATA_W-1:0]        m_tdata
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_RED  = 6'b000100,
        S_SEL  = 6'b001000,
        S_WB   = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t                                state_reg, state_next;
    logic [pee_pkg::CNT_W-1:0]             cnt_reg, cnt_next;
    logic                                  ovf_reg, ovf_next;
    logic                                  last_reg, last_next;
    logic                                  top_is_op_reg, top_is_op_next;
    logic [pee_pkg::VALUE_WIDTH-1:0]       top_val_reg, top_val_next;
    logic [pee_pkg::VALUE_WIDTH-1:0]       b_reg, b_next;
    logic                                  sel_pos_reg, sel_pos_next;
    logic                                  m_valid_reg, m_valid_next;
    logic [pee_pkg::OUT_TDATA_W-1:0]       m_data_reg, m_data_next;

    pee_pkg::entry_t                       stack_mem [pee_pkg::STACK_DEPTH];
    pee_pkg::entry_t                       rd0_reg, rd1_reg;
    pee_pkg::entry_t                       wr_data;
    logic                                  wr_en;
    logic [pee_pkg::ADDR_W-1:0]            rd0_addr, rd1_addr;

    logic [pee_pkg::KIND_W-1:0]            s_kind;
    logic [pee_pkg::DIGIT_W-1:0]           s_digit;
    logic                                  accept;
    logic                                  has_room;
    logic                                  out_free;
    logic                                  bin_hit;
    logic                                  sel_cand;
    logic                                  sel_hit;
    logic [pee_pkg::VALUE_WIDTH-1:0]       alu_res;
    logic [pee_pkg::CNT_W-1:0]             cnt_m1, cnt_m2, cnt_m3;
    logic                                  top_ok;
    logic [pee_pkg::STATUS_W-1:0]          status;

    assign s_kind   = s_tdata[2:0];
    assign s_digit  = s_tdata[6:3];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign has_room = (cnt_reg < pee_pkg::CNT_FULL);
    assign out_free = !m_valid_reg || m_tready;

    assign cnt_m1   = cnt_reg - pee_pkg::CNT_ONE;
    assign cnt_m2   = cnt_reg - pee_pkg::CNT_TWO;
    assign cnt_m3   = cnt_reg - pee_pkg::CNT_THREE;
    assign rd0_addr = cnt_m1[pee_pkg::ADDR_W-1:0];
    // the select check needs the entry below the two operands
    assign rd1_addr = (state_reg == S_RED) ? cnt_m3[pee_pkg::ADDR_W-1:0]
                                           : cnt_m2[pee_pkg::ADDR_W-1:0];

    // rd0 holds the entry just below the pending operand, rd1 the one below it
    assign bin_hit  = !rd0_reg.is_op && rd1_reg.is_op && (rd1_reg.code != pee_pkg::OP_SEL);
    assign sel_cand = !rd0_reg.is_op && !rd1_reg.is_op && (cnt_reg >= pee_pkg::CNT_THREE);
    assign sel_hit  = rd1_reg.is_op && (rd1_reg.code == pee_pkg::OP_SEL);

    // shared arithmetic unit
    always_comb begin
        unique case (rd1_reg.code)
            pee_pkg::OP_ADD: alu_res = rd0_reg.value + b_reg;
            pee_pkg::OP_SUB: alu_res = rd0_reg.value - b_reg;
            pee_pkg::OP_MUL: alu_res = pee_pkg::VALUE_WIDTH'(rd0_reg.value * b_reg);
            default:         alu_res = rd0_reg.value;
        endcase
    end

    assign top_ok = (cnt_reg != '0) && !top_is_op_reg;

    always_comb begin
        priority if (ovf_reg) begin
            status = pee_pkg::ST_OVERFLOW;
        end else if (!top_ok) begin
            status = pee_pkg::ST_MALFORMED;
        end else begin
            status = pee_pkg::ST_OK;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        top_is_op_next = top_is_op_reg;
        top_val_next   = top_val_reg;
        b_next         = b_reg;
        sel_pos_next   = sel_pos_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        wr_en          = 1'b0;
        wr_data        = '{is_op: 1'b0, code: pee_pkg::OP_ADD, value: b_reg};

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    last_next  = s_tlast;
                    state_next = s_tlast ? S_OUT : S_IDLE;
                    if (s_kind == pee_pkg::KIND_DIGIT) begin
                        if (has_room) begin
                            b_next     = pee_pkg::VALUE_WIDTH'(s_digit);
                            state_next = S_RD;
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end else if (s_kind == pee_pkg::KIND_ADD || s_kind == pee_pkg::KIND_SUB ||
                                 s_kind == pee_pkg::KIND_MUL || s_kind == pee_pkg::KIND_SEL) begin
                        if (has_room) begin
                            wr_en          = 1'b1;
                            wr_data        = '{is_op: 1'b1,
                                               code:  pee_pkg::op_code_t'(2'(s_kind - 3'd1)),
                                               value: '0};
                            cnt_next       = cnt_reg + pee_pkg::CNT_ONE;
                            top_is_op_next = 1'b1;
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                end
            end
            S_RD: begin
                state_next = (cnt_reg >= pee_pkg::CNT_TWO) ? S_RED : S_WB;
            end
            S_RED: begin
                if (bin_hit) begin
                    b_next     = alu_res;
                    cnt_next   = cnt_m2;
                    state_next = S_RD;
                end else if (sel_cand) begin
                    sel_pos_next = (rd1_reg.value != '0) &&
                                   !rd1_reg.value[pee_pkg::VALUE_WIDTH-1];
                    state_next   = S_SEL;
                end else begin
                    state_next = S_WB;
                end
            end
            S_SEL: begin
                if (sel_hit) begin
                    b_next     = sel_pos_reg ? rd0_reg.value : b_reg;
                    cnt_next   = cnt_m3;
                    state_next = S_RD;
                end else begin
                    state_next = S_WB;
                end
            end
            S_WB: begin
                wr_en          = 1'b1;
                cnt_next       = cnt_reg + pee_pkg::CNT_ONE;
                top_is_op_next = 1'b0;
                top_val_next   = b_reg;
                state_next     = last_reg ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                // hold until the output register can take the result
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, status,
                                    top_ok ? pee_pkg::OUT_VALUE_W'(top_val_reg)
                                           : pee_pkg::OUT_VALUE_W'(0)};
                    cnt_next     = '0;
                    ovf_next     = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            top_is_op_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            top_is_op_reg <= top_is_op_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_val_reg <= top_val_next;
        b_reg       <= b_next;
        sel_pos_reg <= sel_pos_next;
        m_data_reg  <= m_data_next;
    end

    // stack memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[cnt_reg[pee_pkg::ADDR_W-1:0]] <= wr_data;
        end
        rd0_reg <= stack_mem[rd0_addr];
        rd1_reg <= stack_mem[rd1_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `PEE_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= pee_pkg::CNT_FULL)
    `PEE_ASSERT_NXT(a_bin_pop, aclk, aresetn, (state_reg == S_RED) && bin_hit, cnt_reg == $past(cnt_reg) - pee_pkg::CNT_TWO)
    `PEE_ASSERT_NXT(a_out_clear, aclk, aresetn, (state_reg == S_OUT) && out_free, (cnt_reg == '0) && !ovf_reg && m_valid_reg)

endmodule

`default_nettype wire

// ===== test/tb_prefix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// tb_prefix_expression_evaluator
// Streams prefix-expression tokens into the evaluator and checks every result
// transaction against a stack-machine predictor kept inside the bench. A short
// table of directed tokens is followed by random expressions, mostly
// well-formed, some truncated, scrambled or deep enough to overflow the stack.
// Both channels stall at random, and the receiver once holds off long enough
// to back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_prefix_expression_evaluator;
    import pee_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 150;
    localparam int ITEM_TARGET  = 400;
    localparam int QUIET_FROM   = 340;
    localparam int SETTLE_TICKS = 40;

    // kinds the block ignores
    localparam logic [KIND_W-1:0] KIND_RSVD5 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;

    typedef enum int {BRK_SCRAMBLE, BRK_DEEP, BRK_CUT} broken_kind_t;

    typedef struct packed {
        logic [OUT_VALUE_W-1:0] value;
        logic [STATUS_W-1:0]    status;
    } eval_result_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DIGIT_W-1:0] digit;
        logic               last;
        logic               pinned;
        eval_result_t       want;
    } token_row_t;

    localparam eval_result_t NO_PIN = '0;

    // pinned rows carry a result that follows directly from the token
    localparam token_row_t DIRECTED_ROWS [23] = '{
        '{KIND_RSVD5, 4'd15, 1'b1, 1'b1, '{32'd0,  ST_MALFORMED}},
        '{KIND_DIGIT, 4'd9,  1'b1, 1'b1, '{32'd9,  ST_OK}},
        '{KIND_DIGIT, 4'd15, 1'b1, 1'b1, '{32'd15, ST_OK}},
        '{KIND_MUL,   4'd0,  1'b1, 1'b1, '{32'd0,  ST_MALFORMED}},
        '{KIND_ADD,   4'd15, 1'b0, 1'b0, NO_PIN},
        '{KIND_DIGIT, 4'd7,  1'b0, 1'b0, NO_PIN},
        '{KIND_DIGIT, 4'd3,  1'b1, 1'b0, NO_PIN},
        '{KIND_SUB,   4'd0,  1'b0, 1'b0, NO_PIN},
        '{KIND_DIGIT, 4'd0,  1'b0, 1'b0, NO_PIN},
        '{KIND_DIGIT, 4'd15, 1'b1, 1'b0, NO_PIN},
        '{KIND_MUL,   4'd15, 1'b0, 1'b0, NO_PIN},
        '{KIND_DIGIT, 4'd15, 1'b0, 1'b0, NO_PIN},
        '{KIND_DIGIT, 4'd15, 1'b1, 1'b0, NO_PIN},
        '{KIND_SEL,   4'd0,  1'b0, 1'b0, NO_PIN},
        '{KIND_DIGIT, 4'd1,  1'b0, 1'b0, NO_PIN},
        '{KIND_DIGIT, 4'd4,  1'b0, 1'b0, NO_PIN},
        '{KIND_DIGIT, 4'd5,  1'b1, 1'b0, NO_PIN},
        '{KIND_SEL,   4'd15, 1'b0, 1'b0, NO_PIN},
        '{KIND_RSVD6, 4'd15, 1'b0, 1'b0, NO_PIN},
        '{KIND_DIGIT, 4'd0,  1'b0, 1'b0, NO_PIN},
        '{KIND_RSVD7, 4'd9,  1'b0, 1'b0, NO_PIN},
        '{KIND_DIGIT, 4'd4,  1'b0, 1'b0, NO_PIN},
        '{KIND_DIGIT, 4'd5,  1'b1, 1'b0, NO_PIN}
    };

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [2:0] kind, [6:3] digit, [7] zero
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [31:0] value, [33:32] status, [39:34] zero
    logic [OUT_TDATA_W-1:0] m_tdata;

    prefix_expression_evaluator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // predictor state
    entry_t       held_entries [STACK_DEPTH];
    int           held_count    = 0;
    bit           held_overflow = 1'b0;
    eval_result_t results_due [$];

    int mismatches   = 0;
    int tokens_sent  = 0;
    int cycle_count  = 0;
    int idle_pct     = 30;
    bit rx_hold_req  = 1'b0;

    function automatic void stack_push(logic is_op, op_code_t code,
                                       logic [VALUE_WIDTH-1:0] v);
        if (held_count >= STACK_DEPTH) begin
            held_overflow = 1'b1;
            return;
        end
        held_entries[held_count] = '{is_op, code, v};
        held_count++;
    endfunction

    // Fold one complete operator at the top of the stack; 1 if one was folded.
    function automatic bit fold_top();
        int                     n;
        entry_t                 op, x, y, z;
        logic [VALUE_WIDTH-1:0] r;
        n = held_count;
        if (n >= 3) begin
            op = held_entries[n-3];
            x  = held_entries[n-2];
            y  = held_entries[n-1];
            if (op.is_op && op.code != OP_SEL && !x.is_op && !y.is_op) begin
                case (op.code)
                    OP_ADD:  r = x.value + y.value;
                    OP_SUB:  r = x.value - y.value;
                    default: r = x.value * y.value;
                endcase
                held_count = n - 3;
                stack_push(1'b0, OP_ADD, r);
                return 1'b1;
            end
        end
        if (n >= 4) begin
            op = held_entries[n-4];
            x  = held_entries[n-3];
            y  = held_entries[n-2];
            z  = held_entries[n-1];
            if (op.is_op && op.code == OP_SEL && !x.is_op && !y.is_op && !z.is_op) begin
                // strictly positive condition picks the second operand
                r = (x.value != '0 && !x.value[VALUE_WIDTH-1]) ? y.value : z.value;
                held_count = n - 4;
                stack_push(1'b0, OP_ADD, r);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit take_token(logic [KIND_W-1:0] kind, logic [DIGIT_W-1:0] digit,
                                      logic last, output eval_result_t res);
        bit top_ok;
        res = '0;
        case (kind)
            KIND_ADD: stack_push(1'b1, OP_ADD, '0);
            KIND_SUB: stack_push(1'b1, OP_SUB, '0);
            KIND_MUL: stack_push(1'b1, OP_MUL, '0);
            KIND_SEL: stack_push(1'b1, OP_SEL, '0);
            KIND_DIGIT: begin
                // an operand dropped on a full stack folds nothing
                if (held_count < STACK_DEPTH) begin
                    stack_push(1'b0, OP_ADD, VALUE_WIDTH'(digit));
                    while (fold_top()) begin
                    end
                end else begin
                    held_overflow = 1'b1;
                end
            end
            default: ;
        endcase
        if (!last)
            return 1'b0;
        top_ok = held_count > 0 && !held_entries[held_count-1].is_op;
        if (top_ok)
            res.value = held_entries[held_count-1].value[OUT_VALUE_W-1:0];
        if (held_overflow)
            res.status = ST_OVERFLOW;
        else if (!top_ok)
            res.status = ST_MALFORMED;
        else
            res.status = ST_OK;
        held_count    = 0;
        held_overflow = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("[%0t] mismatch in %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    endtask

    // Hold the token until accepted; valid stays high for the next caller.
    task automatic drive_token(input logic [KIND_W-1:0] kind, input logic [DIGIT_W-1:0] digit,
                               input logic last, input logic pinned, input eval_result_t pin);
        eval_result_t due;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, digit, kind};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (kind <= KIND_SEL)
            tokens_sent++;
        if (take_token(kind, digit, last, due))
            results_due.insert(results_due.size(), pinned ? pin : due);
    endtask

    task automatic send_token(input logic [KIND_W-1:0] kind, input logic [DIGIT_W-1:0] digit,
                              input logic last);
        if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
        drive_token(kind, digit, last, 1'b0, NO_PIN);
    endtask

    // Random prefix expression; cut_at > 0 ends it early on that token.
    task automatic send_expression(input int op_budget, input int cut_at);
        int                need, ops, sent;
        bit                closing;
        logic [KIND_W-1:0] kind;
        need    = 1;
        ops     = 0;
        sent    = 0;
        closing = 1'b0;
        while (!closing) begin
            if ($urandom_range(19, 0) == 0)
                send_token(KIND_W'($urandom_range(KIND_RSVD7, KIND_RSVD5)),
                           DIGIT_W'($urandom_range(15, 0)), 1'b0);
            sent++;
            if (ops < op_budget && $urandom_range(99, 0) < 45) begin
                kind = KIND_W'($urandom_range(KIND_SEL, KIND_ADD));
                ops++;
                need += (kind == KIND_SEL) ? 2 : 1;
            end else begin
                kind = KIND_DIGIT;
                need--;
            end
            closing = (need == 0) || (sent == cut_at);
            send_token(kind, DIGIT_W'($urandom_range(15, 0)), closing);
        end
    endtask

    task automatic send_broken(input broken_kind_t mode);
        int n, m;
        bit all_ops;
        case (mode)
            BRK_SCRAMBLE: begin
                n = $urandom_range(8, 1);
                for (int i = 0; i < n; i++)
                    send_token(KIND_W'($urandom_range(KIND_RSVD7, KIND_DIGIT)),
                               DIGIT_W'($urandom_range(15, 0)), i == n - 1);
            end
            BRK_DEEP: begin
                // run the stack to full or past it, by operators or by bare operands
                all_ops = $urandom_range(1, 0);
                n = all_ops ? STACK_DEPTH - 1 + $urandom_range(5, 0)
                            : STACK_DEPTH + $urandom_range(4, 1);
                for (int i = 0; i < n; i++)
                    send_token(all_ops ? KIND_W'($urandom_range(KIND_SEL, KIND_ADD)) : KIND_DIGIT,
                               DIGIT_W'($urandom_range(15, 0)), !all_ops && i == n - 1);
                if (all_ops) begin
                    m = $urandom_range(3, 1);
                    for (int j = 0; j < m; j++)
                        send_token(KIND_DIGIT, DIGIT_W'($urandom_range(15, 0)), j == m - 1);
                end
            end
            default: send_expression($urandom_range(10, 1), $urandom_range(6, 1));
        endcase
    endtask

    // result side
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(6, 1)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        eval_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
            end else begin
                want = results_due.pop_front();
                if (m_tdata[OUT_VALUE_W-1:0] !== want.value)
                    report_mismatch("value", m_tdata[OUT_VALUE_W-1:0], want.value);
                if (m_tdata[OUT_VALUE_W +: STATUS_W] !== want.status)
                    report_mismatch("status", 32'(m_tdata[OUT_VALUE_W +: STATUS_W]),
                                    32'(want.status));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        bit hold_done, drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_ROWS[i])
            drive_token(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].digit, DIRECTED_ROWS[i].last,
                        DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);

        send_broken(BRK_DEEP);

        while (tokens_sent < ITEM_TARGET) begin
            if (tokens_sent >= QUIET_FROM)
                idle_pct = 0;
            else
                case ((tokens_sent / 60) % 3)
                    0:       idle_pct = 30;
                    1:       idle_pct = 0;
                    default: idle_pct = 55;
                endcase

            // back the block up: receiver stalls while single-token results keep coming
            if (!hold_done && tokens_sent >= 150) begin
                hold_done   = 1'b1;
                rx_hold_req = 1'b1;
                repeat (8) send_token(KIND_DIGIT, DIGIT_W'($urandom_range(15, 0)), 1'b1);
            end

            if (!drain_done && tokens_sent >= 250) begin
                drain_done = 1'b1;
                s_tvalid <= 1'b0;
                while (results_due.size() != 0) @(posedge aclk);
            end

            if ($urandom_range(99, 0) < 85)
                send_expression($urandom_range(12, 0), 0);
            else
                send_broken(broken_kind_t'($urandom_range(BRK_CUT, BRK_SCRAMBLE)));
        end

        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
